>>> rtl/core/nearest_neighbor_pcm_resampler_assert.svh
// assertion macros shared by the resampler rtl
// needs a clock and a synchronous active-high reset at the place of use
`ifndef NEAREST_NEIGHBOR_PCM_RESAMPLER_ASSERT_SVH
`define NEAREST_NEIGHBOR_PCM_RESAMPLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property holds on every clock edge outside reset
`define NNPR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define NNPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define NNPR_ASSERT(label, clk, rst, prop, msg)
`define NNPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/core/nnpr_pkg.sv
// types and constants of the nearest-neighbor pcm resampler
// used by the top level
`default_nettype none

package nnpr_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int RESIDUAL_W  = 13;
  localparam int STEP_W      = 12;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 12;
  localparam int MAX_RESULTS = 64;
  localparam int COUNT_W     = 6;

  typedef logic [RESIDUAL_W-1:0] residual_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes of the configuration port
  localparam cfg_index_t REG_STEP_FRACTION = 4'd0;
  localparam cfg_index_t REG_STEREO        = 4'd1;
  localparam cfg_index_t REG_INPUT_WIDE    = 4'd2;
  localparam cfg_index_t REG_OUTPUT_WIDE   = 4'd3;

  localparam step_t  STEP_MIN        = 12'd4;
  localparam step_t  STEP_RESET      = 12'd256;
  localparam count_t LAST_COUNT      = 6'(MAX_RESULTS - 1);
  localparam logic [7:0] UNSIGNED_OFFSET = 8'h80;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw_left;
    logic [SAMPLE_W-1:0] raw_right;
    logic                last_frame;
  } frame_in_t;

  typedef struct packed {
    sample_t out_left;
    sample_t out_right;
    logic    run_end;
  } frame_out_t;

endpackage

`default_nettype wire

>>> rtl/core/nnpr_stream_if.sv
// valid/ready stream channel carrying one payload struct
// payload type comes in as a type parameter, usually from nnpr_pkg
`default_nettype none

interface nnpr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/nearest_neighbor_pcm_resampler.sv
// Nearest-neighbor pcm resampler, top level.
// Depends on nnpr_pkg, nnpr_stream_if and nearest_neighbor_pcm_resampler_assert.svh.
//
// Usage:
//   source_frame takes one pcm frame per request (nnpr_pkg::frame_in_t): raw left and
//   right bits and a last-of-sound flag. result gives zero or more output frames per
//   input frame (nnpr_pkg::frame_out_t); run_end marks the last one of each run.
//   Registers are to be written through cfg_write / cfg_index / cfg_data while idle,
//   which the block does not enforce; indexes beyond the register list are ignored.
// Sequence:
//   an input frame is taken in an accept step, then gives one result per emit
//   step on the shared residual adder (the emit steps wait while result is
//   stalled), then a wrap step where the same adder takes off one whole frame,
//   or the position restarts at zero after a cut-short run or a last frame.
//   A frame that the position skips goes from accept to wrap and gives nothing.
// Stall:
//   result has a single output register; while it is full and not taken, the
//   emit sequence waits. source_frame.ready is high only in the idle state, so
//   a new frame may be accepted while the last result still waits.
// Reset:
//   rst (synchronous) restores register defaults, clears the residual position
//   and empties the output register.
`default_nettype none

module nearest_neighbor_pcm_resampler #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  nnpr_pkg::cfg_index_t     cfg_index,
  input  nnpr_pkg::cfg_data_t      cfg_data,
  nnpr_stream_if.sink              source_frame,
  nnpr_stream_if.source            result
);

  localparam nnpr_pkg::residual_t WHOLE_FRAME = nnpr_pkg::residual_t'(2 ** FRACTION_BITS);
  localparam nnpr_pkg::residual_t MINUS_WHOLE = ~WHOLE_FRAME + nnpr_pkg::residual_t'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_WRAP
  } state_t;

  state_t state;

  // configuration registers
  nnpr_pkg::step_t step_fraction;
  logic            stereo;
  logic            input_wide;
  logic            output_wide;

  // per-frame working registers
  nnpr_pkg::residual_t residual;
  nnpr_pkg::count_t    emit_count;
  nnpr_pkg::sample_t   left_hold;
  nnpr_pkg::sample_t   right_hold;
  logic                last_hold;

  // output register
  logic                 out_valid;
  nnpr_pkg::frame_out_t out_data;

  nnpr_pkg::step_t     step_eff;
  nnpr_pkg::residual_t addend;
  nnpr_pkg::residual_t sum;
  logic                crosses;
  logic                emit_fire;
  logic                last_emit;
  logic                accept;

  function automatic nnpr_pkg::sample_t convert(input logic [15:0] raw,
                                                input logic in_wide,
                                                input logic out_wide);
    logic [15:0] v;
    v = in_wide ? raw : {raw[7:0] ^ nnpr_pkg::UNSIGNED_OFFSET, 8'h00};
    if (!out_wide) begin
      v = {{8{v[15]}}, v[15:8]};
    end
    return nnpr_pkg::sample_t'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      step_fraction <= nnpr_pkg::STEP_RESET;
      stereo        <= 1'b0;
      input_wide    <= 1'b1;
      output_wide   <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        nnpr_pkg::REG_STEP_FRACTION: step_fraction <= cfg_data[nnpr_pkg::STEP_W-1:0];
        nnpr_pkg::REG_STEREO:        stereo        <= cfg_data[0];
        nnpr_pkg::REG_INPUT_WIDE:    input_wide    <= cfg_data[0];
        nnpr_pkg::REG_OUTPUT_WIDE:   output_wide   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // one shared adder: step advance while emitting, minus one frame when wrapping
  always_comb begin
    step_eff  = (step_fraction < nnpr_pkg::STEP_MIN) ? nnpr_pkg::STEP_MIN : step_fraction;
    addend    = (state == S_WRAP) ? MINUS_WHOLE : nnpr_pkg::residual_t'(step_eff);
    sum       = residual + addend;
    crosses   = (sum >= WHOLE_FRAME);
    emit_fire = (state == S_EMIT) && (!out_valid || result.ready);
    last_emit = crosses || (emit_count == nnpr_pkg::LAST_COUNT);
    accept    = (state == S_IDLE) && source_frame.valid;
  end

  assign source_frame.ready = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.payload     = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      residual   <= '0;
      emit_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            left_hold  <= convert(source_frame.payload.raw_left, input_wide, output_wide);
            right_hold <= stereo ?
                          convert(source_frame.payload.raw_right, input_wide, output_wide) :
                          '0;
            last_hold  <= source_frame.payload.last_frame;
            emit_count <= '0;
            state      <= (residual < WHOLE_FRAME) ? S_EMIT : S_WRAP;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_data.out_left  <= left_hold;
            out_data.out_right <= right_hold;
            out_data.run_end   <= last_emit;
            residual           <= sum;
            emit_count         <= emit_count + nnpr_pkg::count_t'(1);
            if (last_emit) begin
              state <= S_WRAP;
            end
          end
        end
        S_WRAP: begin
          // cut-short runs and the end of a sound restart the position
          if (last_hold || residual < WHOLE_FRAME) begin
            residual <= '0;
          end else begin
            residual <= sum;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "nearest_neighbor_pcm_resampler_assert.svh"

  `NNPR_ASSERT(a_emit_below_frame, clk, rst, (state != S_EMIT) || (residual < WHOLE_FRAME), "emit state entered with residual past one frame")
  `NNPR_ASSERT_NEXT(a_accept_busy, clk, rst, accept, !source_frame.ready, "second frame accepted back to back")
  `NNPR_ASSERT_NEXT(a_count_limit, clk, rst, emit_fire && (emit_count == nnpr_pkg::LAST_COUNT), (state == S_WRAP) && out_data.run_end, "run not closed at the result limit")
  `NNPR_ASSERT_NEXT(a_wrap_to_idle, clk, rst, state == S_WRAP, state == S_IDLE, "wrap step did not return to idle")

endmodule

`default_nettype wire
